/* src/tdr_pkg.sv */
// ----------------------------------------------------------------------------
// tdr_pkg: shared types and constants for the TFTP data receiver
// Event and result words, status and opcode codes, config register indexes.
// ----------------------------------------------------------------------------
package tdr_pkg;

    // Event kinds carried by the operation field
    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_PACKET  = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_STOP    = 2'd3
    } op_t;

    // Transfer status as reported in every result word
    typedef enum logic [2:0] {
        ST_IDLE         = 3'd0,
        ST_RUNNING      = 3'd1,
        ST_COMPLETE     = 3'd2,
        ST_PEER_ERROR   = 3'd3,
        ST_WRONG_SENDER = 3'd4,
        ST_RETRIES      = 3'd5,
        ST_STOPPED      = 3'd6
    } status_t;

    // TFTP opcodes of interest
    localparam logic [15:0] OPC_DATA  = 16'd3;
    localparam logic [15:0] OPC_ERROR = 16'd5;

    localparam logic [9:0] HEADER_BYTES = 10'd4;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FULL_LENGTH = 2'd2;

    // Configuration reset values
    localparam logic       RST_CLIENT_MODE = 1'b0;
    localparam logic [7:0] RST_RETRY_LIMIT = 8'd10;
    localparam logic [9:0] RST_FULL_LENGTH = 10'd516;

    // Input event word
    typedef struct packed {
        logic [1:0]  operation;
        logic [15:0] packet_opcode;
        logic [15:0] packet_block;
        logic [9:0]  packet_length;
        logic        sender_matches;
    } in_item_t;

    // Result word
    typedef struct packed {
        logic        send_request;
        logic        send_ack;
        logic [15:0] ack_block;
        logic        write_payload;
        logic [9:0]  payload_length;
        logic [2:0]  status;
    } out_item_t;

endpackage

/* src/tdr_in_stage.sv */
// ----------------------------------------------------------------------------
// tdr_in_stage: input register of the receiver
// Holds one event word until the core moves it into the result register.
// ----------------------------------------------------------------------------
module tdr_in_stage (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  tdr_pkg::in_item_t  s_data,
    input  logic               advance,
    output logic               item_valid,
    output tdr_pkg::in_item_t  item
);

    logic              valid_reg;
    logic              valid_next;
    tdr_pkg::in_item_t data_reg;

    // Free slot, or the held word leaves this cycle
    assign s_ready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (advance) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

    assign item_valid = valid_reg;
    assign item       = data_reg;

endmodule

/* src/tdr_core.sv */
// ----------------------------------------------------------------------------
// tdr_core: lock-step ACK logic and transfer state
// Config registers, transfer state, and the per-event result computation.
// ----------------------------------------------------------------------------
module tdr_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [tdr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tdr_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                advance,
    input  tdr_pkg::in_item_t                   item,
    output tdr_pkg::out_item_t                  result
);

    // Configuration registers
    logic       client_mode_reg;
    logic [7:0] retry_limit_reg;
    logic [9:0] full_length_reg;

    // Transfer state
    logic             active_reg,  active_next;
    logic [15:0]      acked_reg,   acked_next;
    logic [7:0]       tmo_cnt_reg, tmo_cnt_next;
    tdr_pkg::status_t status_reg,  status_next;

    logic [15:0] expected_block;
    logic [9:0]  plen;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            client_mode_reg <= tdr_pkg::RST_CLIENT_MODE;
            retry_limit_reg <= tdr_pkg::RST_RETRY_LIMIT;
            full_length_reg <= tdr_pkg::RST_FULL_LENGTH;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tdr_pkg::CFG_CLIENT_MODE: client_mode_reg <= cfg_data[0];
                tdr_pkg::CFG_RETRY_LIMIT: retry_limit_reg <= cfg_data[7:0];
                tdr_pkg::CFG_FULL_LENGTH: full_length_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign expected_block = acked_reg + 16'd1;
    assign plen = (item.packet_length >= tdr_pkg::HEADER_BYTES)
                ? (item.packet_length - tdr_pkg::HEADER_BYTES) : 10'd0;

    // Next state and result for the event at the head
    always_comb begin
        active_next  = active_reg;
        acked_next   = acked_reg;
        tmo_cnt_next = tmo_cnt_reg;
        status_next  = status_reg;
        result       = '0;

        if (tdr_pkg::op_t'(item.operation) == tdr_pkg::OP_START) begin
            active_next  = 1'b1;
            acked_next   = 16'd0;
            tmo_cnt_next = 8'd0;
            status_next  = tdr_pkg::ST_RUNNING;
            if (client_mode_reg) begin
                result.send_request = 1'b1;
            end else begin
                result.send_ack = 1'b1;
            end
        end else if (active_reg) begin
            unique case (tdr_pkg::op_t'(item.operation))
                tdr_pkg::OP_PACKET: begin
                    priority if (!item.sender_matches) begin
                        active_next = 1'b0;
                        status_next = tdr_pkg::ST_WRONG_SENDER;
                    end else if (item.packet_opcode == tdr_pkg::OPC_ERROR) begin
                        active_next = 1'b0;
                        status_next = tdr_pkg::ST_PEER_ERROR;
                    end else if (item.packet_opcode == tdr_pkg::OPC_DATA &&
                                 item.packet_block == expected_block) begin
                        result.write_payload  = 1'b1;
                        result.payload_length = plen;
                        result.send_ack       = 1'b1;
                        result.ack_block      = item.packet_block;
                        acked_next            = item.packet_block;
                        tmo_cnt_next          = 8'd0;
                        if (item.packet_length < full_length_reg) begin
                            active_next = 1'b0;
                            status_next = tdr_pkg::ST_COMPLETE;
                        end
                    end else begin
                        // Duplicate, out of order or unknown: re-send last ACK
                        result.send_ack  = 1'b1;
                        result.ack_block = acked_reg;
                    end
                end
                tdr_pkg::OP_TIMEOUT: begin
                    if (tmo_cnt_reg >= retry_limit_reg) begin
                        active_next = 1'b0;
                        status_next = tdr_pkg::ST_RETRIES;
                    end else begin
                        tmo_cnt_next     = tmo_cnt_reg + 8'd1;
                        result.send_ack  = 1'b1;
                        result.ack_block = acked_reg;
                    end
                end
                tdr_pkg::OP_STOP: begin
                    active_next = 1'b0;
                    status_next = tdr_pkg::ST_STOPPED;
                end
                default: ;
            endcase
        end

        result.status = status_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            acked_reg   <= 16'd0;
            tmo_cnt_reg <= 8'd0;
            status_reg  <= tdr_pkg::ST_IDLE;
        end else if (advance) begin
            active_reg  <= active_next;
            acked_reg   <= acked_next;
            tmo_cnt_reg <= tmo_cnt_next;
            status_reg  <= status_next;
        end
    end

endmodule

/* src/tdr_out_reg.sv */
// ----------------------------------------------------------------------------
// tdr_out_reg: result register of the receiver
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module tdr_out_reg (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                item_valid,
    output logic                advance,
    input  tdr_pkg::out_item_t  result,
    output logic                m_valid,
    input  logic                m_ready,
    output tdr_pkg::out_item_t  m_data
);

    logic               valid_reg;
    logic               valid_next;
    tdr_pkg::out_item_t data_reg;

    // Move a word in when the register is empty or drains this cycle
    assign advance = item_valid && (!valid_reg || m_ready);

    always_comb begin
        valid_next = valid_reg;
        if (advance) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

/* src/tftp_data_receiver.sv */
// ----------------------------------------------------------------------------
// tftp_data_receiver: receiving side of a lock-step TFTP transfer
// Turns start, packet, timeout and stop events into request/ACK/write words.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one event word: start, received packet
//   header, timeout tick or stop request. Every event yields exactly one
//   result word on m_valid/m_ready/m_data: request and ACK flags, the block
//   to acknowledge, payload write and length, and the transfer status.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write client_mode (0),
//   retry_limit (1) and full_packet_length (2); cfg_ready is always high.
//   Write the registers only while no event is in flight.
//   The result word passes the input register, then the event logic
//   feeding the result register. Throughput is one word per cycle while
//   m_ready stays high.
//   When m_ready is low the result register holds, the input register fills
//   and then s_ready drops; nothing is lost or repeated.
//   Reset (aresetn low, synchronous) empties both registers, loads the
//   config defaults and returns the transfer state to idle.
// ----------------------------------------------------------------------------
module tftp_data_receiver (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  tdr_pkg::in_item_t               s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output tdr_pkg::out_item_t              m_data,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [tdr_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tdr_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic               advance;
    logic               item_valid;
    tdr_pkg::in_item_t  item;
    tdr_pkg::out_item_t result;

    assign cfg_ready = 1'b1;

    tdr_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    tdr_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (advance),
        .item      (item),
        .result    (result)
    );

    tdr_out_reg u_out_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .advance    (advance),
        .result     (result),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // A payload write always comes with an ACK of that block
    a_write_has_ack: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.write_payload) |-> m_data.send_ack)
        else $error("payload write without ACK");

    // A read request only opens a running transfer, never with an ACK
    a_request_running: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.send_request) |->
            (!m_data.send_ack && m_data.status == tdr_pkg::ST_RUNNING))
        else $error("read request with bad status or ACK");

    // With the result register empty the input side must take a word
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // Reset leaves no result pending
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule
